[sv/biq_pkg.sv]
// Package for the second-order IIR filter core: widths, register indexes,
// reset values, datapath command types and the round-and-saturate function.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package biq_pkg;

   // Fixed widths of the coefficient registers and of the filter values.
   localparam int COEF_W          = 16;
   localparam int VAL_W           = 28;
   localparam int PROD_W          = COEF_W + VAL_W;
   localparam int ACC_W           = PROD_W + 2;
   localparam int NUM_REGS        = 7;
   localparam int CSR_IDX_W       = 3;
   localparam int VAL_FRAC_BITS   = 8;

   // Defaults for the top-level parameters.
   localparam int SAMPLE_BITS_DEF    = 12;
   localparam int COEF_FRAC_BITS_DEF = 13;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_INPUT_GAIN = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FF_COEF_0  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FF_COEF_1  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FF_COEF_2  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FB_COEF_0  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_FB_COEF_1  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_FB_COEF_2  = 3'd6;

   // Reset values of the registers, signed Q3.13.
   localparam logic signed [COEF_W-1:0] RST_INPUT_GAIN = 16'sd795;
   localparam logic signed [COEF_W-1:0] RST_FF_COEF_0  = 16'sd8192;
   localparam logic signed [COEF_W-1:0] RST_FF_COEF_1  = 16'sd16384;
   localparam logic signed [COEF_W-1:0] RST_FF_COEF_2  = 16'sd8192;
   localparam logic signed [COEF_W-1:0] RST_FB_COEF_0  = 16'sd8192;
   localparam logic signed [COEF_W-1:0] RST_FB_COEF_1  = 16'sd7946;
   localparam logic signed [COEF_W-1:0] RST_FB_COEF_2  = -16'sd2703;

   // Saturation limits of the filter values.
   localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

   // Operand pair fed to the shared multiplier.
   typedef enum logic [2:0] {
      MUL_GAIN,
      MUL_FF0,
      MUL_FF1,
      MUL_FF2,
      MUL_FB0,
      MUL_FB1,
      MUL_FB2
   } mul_sel_type;

   // Accumulator operation.
   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD
   } acc_op_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        load_sample;
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      logic        load_x;
      logic        load_f;
      logic        load_y;
   } dp_cmd_type;

   // Adds half an LSB, shifts right arithmetically and clamps to the value range.
   function automatic logic signed [VAL_W-1:0] round_sat(
      input logic signed [ACC_W-1:0] v,
      input int unsigned             sh
   );
      logic signed [ACC_W-1:0] half;
      logic signed [ACC_W-1:0] t;
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      half = (sh > 0) ? (ACC_W'(1) << (sh - 1)) : '0;
      t    = (v + half) >>> sh;
      hi   = {{(ACC_W-VAL_W){VAL_MAX[VAL_W-1]}}, VAL_MAX};
      lo   = {{(ACC_W-VAL_W){VAL_MIN[VAL_W-1]}}, VAL_MIN};
      if (t > hi) begin
         return VAL_MAX;
      end else if (t < lo) begin
         return VAL_MIN;
      end else begin
         return t[VAL_W-1:0];
      end
   endfunction

endpackage

[sv/biq_req_if.sv]
// Request channel of the filter core: valid, ready and one converter sample.
// Depends on biq_pkg for the default sample width.
`timescale 1ns / 1ps

interface biq_req_if
   import biq_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

[sv/biq_rsp_if.sv]
// Result channel of the filter core: valid, ready and one filtered value.
// Depends on biq_pkg for the value width.
`timescale 1ns / 1ps

interface biq_rsp_if
   import biq_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic signed [VAL_W-1:0] filtered;

   modport source (output valid, output filtered, input ready);
   modport sink   (input valid, input filtered, output ready);
endinterface

[sv/biq_ctrl.sv]
// Controller of the filter core: sequences the shared multiplier and the
// accumulator and runs both handshakes. Depends on biq_pkg.
`timescale 1ns / 1ps

module biq_ctrl
   import biq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output dp_cmd_type cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_GAIN,
      S_SCALE,
      S_FF_LOAD,
      S_FF_ADD1,
      S_FF_ADD2,
      S_F_ROUND,
      S_FB_ADD1,
      S_FB_ADD2,
      S_OUT
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;
   logic      req_take;

   // The output register is free when empty or being taken this cycle.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) || ((state_ff == S_OUT) && out_free);
   assign req_take  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // The result flag drops when taken and rises when a new result is registered.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if ((state_ff == S_OUT) && out_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Datapath commands for each step of the schedule.
   always_comb begin
      cmd             = '0;
      cmd.mul_sel     = MUL_GAIN;
      cmd.acc_op      = ACC_HOLD;
      cmd.load_sample = req_take;
      unique case (state_ff)
         S_IDLE: begin
         end
         S_GAIN: begin
            cmd.mul_sel = MUL_GAIN;
         end
         S_SCALE: begin
            cmd.load_x  = 1'b1;
            cmd.mul_sel = MUL_FF1;
         end
         S_FF_LOAD: begin
            cmd.acc_op  = ACC_LOAD;
            cmd.mul_sel = MUL_FF2;
         end
         S_FF_ADD1: begin
            cmd.acc_op  = ACC_ADD;
            cmd.mul_sel = MUL_FF0;
         end
         S_FF_ADD2: begin
            cmd.acc_op  = ACC_ADD;
            cmd.mul_sel = MUL_FB1;
         end
         S_F_ROUND: begin
            cmd.load_f  = 1'b1;
            cmd.acc_op  = ACC_LOAD;
            cmd.mul_sel = MUL_FB2;
         end
         S_FB_ADD1: begin
            cmd.acc_op  = ACC_ADD;
            cmd.mul_sel = MUL_FB0;
         end
         S_FB_ADD2: begin
            cmd.acc_op  = ACC_ADD;
         end
         S_OUT: begin
            cmd.load_y = out_free;
         end
         default: begin
         end
      endcase
   end

   // State register and the result valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         unique case (state_ff)
            S_IDLE: begin
               if (req_take) begin
                  state_ff <= S_GAIN;
               end
            end
            S_GAIN:    state_ff <= S_SCALE;
            S_SCALE:   state_ff <= S_FF_LOAD;
            S_FF_LOAD: state_ff <= S_FF_ADD1;
            S_FF_ADD1: state_ff <= S_FF_ADD2;
            S_FF_ADD2: state_ff <= S_F_ROUND;
            S_F_ROUND: state_ff <= S_FB_ADD1;
            S_FB_ADD1: state_ff <= S_FB_ADD2;
            S_FB_ADD2: state_ff <= S_OUT;
            S_OUT: begin
               if (out_free) begin
                  state_ff <= req_take ? S_GAIN : S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

[sv/biq_datapath.sv]
// Datapath of the filter core: coefficient registers, history words, one shared
// multiplier, the accumulator and the result register. Depends on biq_pkg.
`timescale 1ns / 1ps

module biq_datapath
   import biq_pkg::*;
#(
   parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
   parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  dp_cmd_type              cmd,
   input  logic [SAMPLE_BITS-1:0]  req_sample,
   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [COEF_W-1:0]       csr_wdata,
   output logic signed [VAL_W-1:0] rsp_filtered
);

   localparam int unsigned X_SHIFT = COEF_FRAC_BITS - VAL_FRAC_BITS;
   localparam int unsigned Y_SHIFT = COEF_FRAC_BITS;

   logic signed [COEF_W-1:0] gain_ff;
   logic signed [COEF_W-1:0] ff0_ff;
   logic signed [COEF_W-1:0] ff1_ff;
   logic signed [COEF_W-1:0] ff2_ff;
   logic signed [COEF_W-1:0] fb0_ff;
   logic signed [COEF_W-1:0] fb1_ff;
   logic signed [COEF_W-1:0] fb2_ff;

   logic [SAMPLE_BITS-1:0]   sample_ff;
   logic signed [VAL_W-1:0]  x_ff;
   logic signed [VAL_W-1:0]  f_ff;
   logic signed [VAL_W-1:0]  xp0_ff;
   logic signed [VAL_W-1:0]  xp1_ff;
   logic signed [VAL_W-1:0]  yp0_ff;
   logic signed [VAL_W-1:0]  yp1_ff;
   logic signed [VAL_W-1:0]  out_ff;

   logic signed [COEF_W-1:0] mul_a;
   logic signed [VAL_W-1:0]  mul_b;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  prod_ext;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [VAL_W-1:0]  x_in;
   logic signed [VAL_W-1:0]  acc_round;

   // Configuration writes; an index past the last register is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= RST_INPUT_GAIN;
         ff0_ff  <= RST_FF_COEF_0;
         ff1_ff  <= RST_FF_COEF_1;
         ff2_ff  <= RST_FF_COEF_2;
         fb0_ff  <= RST_FB_COEF_0;
         fb1_ff  <= RST_FB_COEF_1;
         fb2_ff  <= RST_FB_COEF_2;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_INPUT_GAIN: gain_ff <= csr_wdata;
            REG_FF_COEF_0:  ff0_ff  <= csr_wdata;
            REG_FF_COEF_1:  ff1_ff  <= csr_wdata;
            REG_FF_COEF_2:  ff2_ff  <= csr_wdata;
            REG_FB_COEF_0:  fb0_ff  <= csr_wdata;
            REG_FB_COEF_1:  fb1_ff  <= csr_wdata;
            REG_FB_COEF_2:  fb2_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      case (cmd.mul_sel)
         MUL_GAIN: begin
            mul_a = gain_ff;
            mul_b = {{(VAL_W-SAMPLE_BITS){1'b0}}, sample_ff};
         end
         MUL_FF0: begin
            mul_a = ff0_ff;
            mul_b = x_ff;
         end
         MUL_FF1: begin
            mul_a = ff1_ff;
            mul_b = xp0_ff;
         end
         MUL_FF2: begin
            mul_a = ff2_ff;
            mul_b = xp1_ff;
         end
         MUL_FB0: begin
            mul_a = fb0_ff;
            mul_b = f_ff;
         end
         MUL_FB1: begin
            mul_a = fb1_ff;
            mul_b = yp0_ff;
         end
         MUL_FB2: begin
            mul_a = fb2_ff;
            mul_b = yp1_ff;
         end
         default: begin
            mul_a = gain_ff;
            mul_b = x_ff;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;
   assign prod_ext = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};

   // Accumulator update.
   always_comb begin
      case (cmd.acc_op)
         ACC_LOAD: acc_in = prod_ext;
         ACC_ADD:  acc_in = acc_ff + prod_ext;
         default:  acc_in = acc_ff;
      endcase
   end

   // The scaled input comes straight from the gain product.
   assign x_in      = round_sat(prod_ext, X_SHIFT);
   assign acc_round = round_sat(acc_ff, Y_SHIFT);

   // Multiplier, accumulator and intermediate value registers.
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      if (cmd.load_sample) begin
         sample_ff <= req_sample;
      end
      if (cmd.load_x) begin
         x_ff <= x_in;
      end
      if (cmd.load_f) begin
         f_ff <= acc_round;
      end
      if (cmd.load_y) begin
         out_ff <= acc_round;
      end
   end

   // History words, cleared at reset and shifted when a result is produced.
   always_ff @(posedge clock) begin
      if (reset) begin
         xp0_ff <= '0;
         xp1_ff <= '0;
         yp0_ff <= '0;
         yp1_ff <= '0;
      end else if (cmd.load_y) begin
         xp0_ff <= x_ff;
         xp1_ff <= xp0_ff;
         yp0_ff <= acc_round;
         yp1_ff <= yp0_ff;
      end
   end

   assign rsp_filtered = out_ff;

endmodule

[sv/second_order_iir_filter_core.sv]
// Top level of the second-order IIR filter core (direct form 1 biquad).
// Depends on biq_pkg, biq_req_if, biq_rsp_if, biq_ctrl and biq_datapath.
//
//  Channel  Direction  Contents
//  req      in         sample, SAMPLE_BITS unsigned converter code
//  rsp      out        filtered, 28 bits signed, 8 fraction bits, saturated
//  csr      in         csr_we, csr_index (3 bits), csr_wdata (16 bits)
//
// Each request sends its seven products one after another through the single
// shared multiplier, so a new request waits until the previous one is finished.
// The next request is taken in the cycle its predecessor's result is registered.
// A stalled result holds in the output register; the block then waits before
// writing the next one. Reset restores the coefficients and clears the history.
`timescale 1ns / 1ps

module second_order_iir_filter_core
   import biq_pkg::*;
#(
   parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
   parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   biq_req_if.sink              req_if,
   biq_rsp_if.source            rsp_if,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COEF_W-1:0]    csr_wdata
);

   dp_cmd_type cmd;

   // Sequencer for the multiply-accumulate schedule and the handshakes.
   biq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd)
   );

   // Arithmetic, coefficients and history.
   biq_datapath #(
      .SAMPLE_BITS    (SAMPLE_BITS),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .req_sample   (req_if.sample),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .rsp_filtered (rsp_if.filtered)
   );

endmodule
